FILE: rtl/closed_spline_nearest_segment_unit_defines.svh
// Assertion macros used by the RTL of the nearest segment unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CLOSED_SPLINE_NEAREST_SEGMENT_UNIT_DEFINES_SVH
`define CLOSED_SPLINE_NEAREST_SEGMENT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, pre, post)
`define ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: rtl/csns_pkg.sv
`default_nettype none
package csns_pkg;

  // Polyline resolution (power of two) and derived widths
  localparam int SEGMENTS   = 64;
  localparam int SEG_W      = $clog2(SEGMENTS);
  localparam int T_SHIFT    = 16 - SEG_W;
  localparam int MAX_POINTS = 24;
  localparam int PT_W       = $clog2(MAX_POINTS);
  localparam int DIV_STEPS  = 16;
  localparam int DIVC_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [14:0] query_x;
    logic [14:0] query_y;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  segment_index;
    logic [30:0] nearest_dist_sq;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COEF, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_VEC, ST_DOT,
    ST_LSUM, ST_CLAMP, ST_DIV, ST_FOOT, ST_DIFF, ST_SQ, ST_CMP, ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_COEF, OP_MUL1, OP_MUL2, OP_MUL3, OP_SUM, OP_VEC,
    OP_DOT, OP_LSUM, OP_CLAMP, OP_DIV, OP_FOOT, OP_DIFF, OP_SQ, OP_CMP_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             first;
    logic             last;
    logic [SEG_W-1:0] seg;
  } cmd_t;

  typedef struct packed {
    logic div_need;
  } status_t;

  localparam logic [PT_W-1:0] CURVE_COUNT [4] = '{5'd13, 5'd24, 5'd23, 5'd24};

  // Control points {x, y}, integer pixels
  localparam logic [17:0] CURVE_PTS [4][MAX_POINTS] = '{
    '{ {9'd160,9'd199},{9'd225,9'd199},{9'd275,9'd190},{9'd292,9'd154},
       {9'd292,9'd88}, {9'd275,9'd52}, {9'd225,9'd43}, {9'd95,9'd43},
       {9'd45,9'd52},  {9'd28,9'd88},  {9'd28,9'd154}, {9'd45,9'd190},
       {9'd95,9'd199}, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0,
       18'd0, 18'd0, 18'd0, 18'd0 },
    '{ {9'd160,9'd198},{9'd220,9'd198},{9'd254,9'd197},{9'd276,9'd188},
       {9'd287,9'd174},{9'd289,9'd159},{9'd284,9'd143},{9'd270,9'd125},
       {9'd239,9'd99}, {9'd207,9'd73}, {9'd187,9'd58}, {9'd174,9'd52},
       {9'd160,9'd50}, {9'd146,9'd52}, {9'd133,9'd59}, {9'd121,9'd73},
       {9'd101,9'd101},{9'd85,9'd124}, {9'd72,9'd144}, {9'd64,9'd161},
       {9'd63,9'd175}, {9'd69,9'd187}, {9'd82,9'd195}, {9'd104,9'd198} },
    '{ {9'd160,9'd198},{9'd204,9'd188},{9'd244,9'd174},{9'd270,9'd159},
       {9'd285,9'd137},{9'd289,9'd108},{9'd286,9'd82}, {9'd274,9'd64},
       {9'd258,9'd55}, {9'd235,9'd52}, {9'd198,9'd52}, {9'd160,9'd52},
       {9'd122,9'd52}, {9'd84,9'd52},  {9'd62,9'd56},  {9'd47,9'd66},
       {9'd37,9'd82},  {9'd32,9'd104}, {9'd34,9'd128}, {9'd44,9'd148},
       {9'd61,9'd164}, {9'd89,9'd178}, {9'd124,9'd190}, 18'd0 },
    '{ {9'd160,9'd198},{9'd208,9'd198},{9'd244,9'd197},{9'd266,9'd188},
       {9'd281,9'd171},{9'd288,9'd148},{9'd289,9'd121},{9'd286,9'd94},
       {9'd278,9'd73}, {9'd266,9'd59}, {9'd252,9'd53}, {9'd238,9'd53},
       {9'd219,9'd59}, {9'd188,9'd71}, {9'd151,9'd85}, {9'd113,9'd99},
       {9'd78,9'd112}, {9'd52,9'd124}, {9'd38,9'd138}, {9'd32,9'd154},
       {9'd34,9'd171}, {9'd44,9'd187}, {9'd62,9'd196}, {9'd88,9'd198} }
  };

  // Register indexes
  localparam logic REG_CURVE_SELECT = 1'b0;

endpackage
`default_nettype wire

FILE: rtl/closed_spline_nearest_segment_unit.sv
`default_nettype none
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_word  (query_x, query_y)
// out      out_valid / out_ready  out_word (segment_index, nearest_dist_sq)
// cfg      APB write, pready = 1  curve_select at byte address 0
//
// One query takes SEGMENTS+1 spline samples; each segment adds the vector, dot,
// length sum, clamp, foot, difference, square and compare steps, plus the
// bit-serial projection divider when the foot falls inside it. Synchronous
// reset; curve_select returns to 0. A new query is taken while the last
// result waits in the output register; the final step stalls until that
// register is free.
`include "closed_spline_nearest_segment_unit_defines.svh"
module closed_spline_nearest_segment_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire csns_pkg::in_word_t   in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output csns_pkg::out_word_t       out_word,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [1:0]          curve_select;
  csns_pkg::cmd_t      cmd;
  csns_pkg::status_t   status;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == csns_pkg::REG_CURVE_SELECT) ? {30'b0, curve_select} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_select <= '0;
    end else if (psel && penable && pwrite && paddr[2] == csns_pkg::REG_CURVE_SELECT) begin
      curve_select <= pwdata[1:0];
    end
  end

  csns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  csns_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_word      (in_word),
    .curve_select (curve_select),
    .status       (status),
    .out_word     (out_word)
  );

  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `ASSERT_IMP(a_out_from_publish, $rose(out_valid),
              $past(cmd.op) == csns_pkg::OP_CMP_OUT)
  `ASSERT_NEXT(a_skip_divider, cmd.op == csns_pkg::OP_CLAMP && !status.div_need,
               cmd.op == csns_pkg::OP_FOOT)

endmodule
`default_nettype wire

FILE: rtl/csns_ctrl.sv
`default_nettype none
module csns_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire csns_pkg::status_t  status,
  output csns_pkg::cmd_t          cmd
);

  csns_pkg::state_t               state, state_next;
  logic                           first;
  logic [csns_pkg::SEG_W-1:0]     seg;
  logic [csns_pkg::DIVC_W-1:0]    divc;
  logic                           last;
  logic                           out_free;

  assign last     = (seg == csns_pkg::SEG_W'(csns_pkg::SEGMENTS - 1));
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == csns_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      csns_pkg::ST_IDLE:   if (in_valid) state_next = csns_pkg::ST_COEF;
      csns_pkg::ST_COEF:   state_next = csns_pkg::ST_MUL1;
      csns_pkg::ST_MUL1:   state_next = csns_pkg::ST_MUL2;
      csns_pkg::ST_MUL2:   state_next = csns_pkg::ST_MUL3;
      csns_pkg::ST_MUL3:   state_next = csns_pkg::ST_SUM;
      csns_pkg::ST_SUM:    state_next = first ? csns_pkg::ST_COEF : csns_pkg::ST_VEC;
      csns_pkg::ST_VEC:    state_next = csns_pkg::ST_DOT;
      csns_pkg::ST_DOT:    state_next = csns_pkg::ST_LSUM;
      csns_pkg::ST_LSUM:   state_next = csns_pkg::ST_CLAMP;
      csns_pkg::ST_CLAMP:
        state_next = status.div_need ? csns_pkg::ST_DIV : csns_pkg::ST_FOOT;
      csns_pkg::ST_DIV:
        if (divc == csns_pkg::DIVC_W'(csns_pkg::DIV_STEPS - 1)) begin
          state_next = csns_pkg::ST_FOOT;
        end
      csns_pkg::ST_FOOT:   state_next = csns_pkg::ST_DIFF;
      csns_pkg::ST_DIFF:   state_next = csns_pkg::ST_SQ;
      csns_pkg::ST_SQ:     state_next = csns_pkg::ST_CMP;
      csns_pkg::ST_CMP:    state_next = last ? csns_pkg::ST_FINISH : csns_pkg::ST_COEF;
      csns_pkg::ST_FINISH: if (out_free) state_next = csns_pkg::ST_IDLE;
      default:             state_next = csns_pkg::ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd.first = first;
    cmd.last  = 1'b0;
    cmd.seg   = seg;
    unique case (state)
      csns_pkg::ST_IDLE:   cmd.op = in_valid ? csns_pkg::OP_LOAD : csns_pkg::OP_IDLE;
      csns_pkg::ST_COEF:   cmd.op = csns_pkg::OP_COEF;
      csns_pkg::ST_MUL1:   cmd.op = csns_pkg::OP_MUL1;
      csns_pkg::ST_MUL2:   cmd.op = csns_pkg::OP_MUL2;
      csns_pkg::ST_MUL3:   cmd.op = csns_pkg::OP_MUL3;
      csns_pkg::ST_SUM:    cmd.op = csns_pkg::OP_SUM;
      csns_pkg::ST_VEC:    cmd.op = csns_pkg::OP_VEC;
      csns_pkg::ST_DOT:    cmd.op = csns_pkg::OP_DOT;
      csns_pkg::ST_LSUM:   cmd.op = csns_pkg::OP_LSUM;
      csns_pkg::ST_CLAMP:  cmd.op = csns_pkg::OP_CLAMP;
      csns_pkg::ST_DIV:    cmd.op = csns_pkg::OP_DIV;
      csns_pkg::ST_FOOT:   cmd.op = csns_pkg::OP_FOOT;
      csns_pkg::ST_DIFF:   cmd.op = csns_pkg::OP_DIFF;
      csns_pkg::ST_SQ:     cmd.op = csns_pkg::OP_SQ;
      csns_pkg::ST_CMP:    cmd.op = csns_pkg::OP_CMP_OUT;
      csns_pkg::ST_FINISH: begin
        cmd.op   = out_free ? csns_pkg::OP_CMP_OUT : csns_pkg::OP_IDLE;
        cmd.last = 1'b1;
      end
      default:             cmd.op = csns_pkg::OP_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= csns_pkg::ST_IDLE;
      first     <= 1'b0;
      seg       <= '0;
      divc      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == csns_pkg::ST_IDLE && in_valid) begin
        first <= 1'b1;
        seg   <= '0;
      end
      if (state == csns_pkg::ST_SUM) first <= 1'b0;
      if (state == csns_pkg::ST_CMP) seg <= seg + 1'b1;
      if (state == csns_pkg::ST_CLAMP) divc <= '0;
      if (state == csns_pkg::ST_DIV) divc <= divc + 1'b1;
      if (state == csns_pkg::ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/csns_datapath.sv
`default_nettype none
module csns_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire csns_pkg::cmd_t      cmd,
  input  wire csns_pkg::in_word_t  in_word,
  input  wire logic [1:0]          curve_select,
  output csns_pkg::status_t        status,
  output csns_pkg::out_word_t      out_word
);

  localparam int PW = csns_pkg::PT_W;
  localparam int SW = csns_pkg::SEG_W;

  logic [14:0]              q [2];
  logic [1:0]               sel;
  logic [PW-1:0]            cnt, j;
  logic [SW-1:0]            r;
  logic [16:0]              t, t2, t3;
  logic signed [31:0]       c0 [2];
  logic signed [13:0]       c1 [2], c2 [2], c3 [2];
  logic signed [31:0]       pr1 [2], pr2 [2], pr3 [2];
  logic signed [17:0]       a [2], b [2];
  logic signed [18:0]       v [2];
  logic signed [19:0]       w [2];
  logic signed [39:0]       pvv [2], pwv [2];
  logic signed [39:0]       len2, dot;
  logic signed [40:0]       rem;
  logic [16:0]              u;
  logic signed [36:0]       f [2];
  logic signed [21:0]       dd [2];
  logic signed [43:0]       sq [2];
  logic signed [44:0]       best;
  logic [SW-1:0]            best_idx;

  // Combinational helpers
  logic [PW-1:0]            i0, i2, i3, jp1;
  logic [PW:0]              j2;
  logic [SW:0]              rn;
  logic [17:0]              pt [4];
  logic signed [13:0]       ps [4];
  logic signed [13:0]       nc1 [2], nc2 [2], nc3 [2];
  logic signed [31:0]       ssum [2];
  logic signed [17:0]       smp [2];
  logic signed [40:0]       rem2;
  logic                     ge;
  logic signed [20:0]       fr [2];
  logic signed [21:0]       ndd [2];
  logic signed [44:0]       seg_dsq;
  logic                     proj_zero;

  // Neighbor control point indexes with wraparound
  always_comb begin
    jp1 = (j + 1'b1 == cnt) ? '0 : j + 1'b1;
    i0  = (j == '0) ? cnt - 1'b1 : j - 1'b1;
    i2  = jp1;
    j2  = {1'b0, j} + (PW+1)'(2);
    i3  = (j2 >= {1'b0, cnt}) ? PW'(j2 - {1'b0, cnt}) : PW'(j2);
    rn  = {1'b0, r} + (SW+1)'(cnt);
  end

  // Spline coefficients for both axes
  always_comb begin
    pt[0] = csns_pkg::CURVE_PTS[sel][i0];
    pt[1] = csns_pkg::CURVE_PTS[sel][j];
    pt[2] = csns_pkg::CURVE_PTS[sel][i2];
    pt[3] = csns_pkg::CURVE_PTS[sel][i3];
    for (int ax = 0; ax < 2; ax++) begin
      for (int k = 0; k < 4; k++) begin
        ps[k] = (ax == 0) ? $signed({5'b0, pt[k][17:9]}) : $signed({5'b0, pt[k][8:0]});
      end
      nc1[ax] = ps[2] - ps[0];
      nc2[ax] = (ps[0] <<< 1) - ps[1] * 14'sd5 + (ps[2] <<< 2) - ps[3];
      nc3[ax] = ps[1] * 14'sd3 - ps[0] - ps[2] * 14'sd3 + ps[3];
    end
  end

  // Sample sum, divider step, foot offset and segment distance
  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      ssum[ax] = c0[ax] + pr1[ax] + pr2[ax] + pr3[ax] + 32'sd1024;
      smp[ax]  = 18'(ssum[ax] >>> 11);
      fr[ax]   = 21'((f[ax] + 37'sd32768) >>> 16);
      ndd[ax]  = $signed({7'b0, q[ax]}) - 22'(a[ax]) - 22'(fr[ax]);
    end
    rem2      = {rem[39:0], 1'b0};
    ge        = (rem2 >= 41'(len2));
    seg_dsq   = 45'(sq[0]) + 45'(sq[1]);
    proj_zero = (len2 == '0) || (dot <= '0);
  end

  assign status.div_need = !proj_zero && (dot < len2);

  // Datapath registers, one operation per command
  always_ff @(posedge clk) begin
    case (cmd.op)
      csns_pkg::OP_LOAD: begin
        q[0] <= in_word.query_x;
        q[1] <= in_word.query_y;
        sel  <= curve_select;
        cnt  <= csns_pkg::CURVE_COUNT[curve_select];
        j    <= '0;
        r    <= '0;
      end
      csns_pkg::OP_COEF: begin
        t <= 17'({r, csns_pkg::T_SHIFT'(0)});
        for (int ax = 0; ax < 2; ax++) begin
          c0[ax] <= (ax == 0) ? $signed({6'b0, pt[1][17:9], 17'b0})
                              : $signed({6'b0, pt[1][8:0], 17'b0});
          c1[ax] <= nc1[ax];
          c2[ax] <= nc2[ax];
          c3[ax] <= nc3[ax];
        end
      end
      csns_pkg::OP_MUL1: begin
        t2 <= 17'((34'(t) * 34'(t)) >> 16);
        for (int ax = 0; ax < 2; ax++) pr1[ax] <= c1[ax] * $signed({1'b0, t});
      end
      csns_pkg::OP_MUL2: begin
        t3 <= 17'((34'(t2) * 34'(t)) >> 16);
        for (int ax = 0; ax < 2; ax++) pr2[ax] <= c2[ax] * $signed({1'b0, t2});
      end
      csns_pkg::OP_MUL3: begin
        for (int ax = 0; ax < 2; ax++) pr3[ax] <= c3[ax] * $signed({1'b0, t3});
      end
      csns_pkg::OP_SUM: begin
        for (int ax = 0; ax < 2; ax++) begin
          if (cmd.first) a[ax] <= smp[ax];
          else b[ax] <= smp[ax];
        end
        // advance to the next sample parameter
        r <= rn[SW-1:0];
        if (rn[SW]) j <= jp1;
      end
      csns_pkg::OP_VEC: begin
        for (int ax = 0; ax < 2; ax++) begin
          v[ax] <= 19'(b[ax]) - 19'(a[ax]);
          w[ax] <= $signed({5'b0, q[ax]}) - 20'(a[ax]);
        end
      end
      csns_pkg::OP_DOT: begin
        for (int ax = 0; ax < 2; ax++) begin
          pvv[ax] <= 40'(v[ax]) * 40'(v[ax]);
          pwv[ax] <= 40'(w[ax]) * 40'(v[ax]);
        end
      end
      csns_pkg::OP_LSUM: begin
        len2 <= pvv[0] + pvv[1];
        dot  <= pwv[0] + pwv[1];
      end
      csns_pkg::OP_CLAMP: begin
        rem <= 41'(dot);
        if (proj_zero) u <= '0;
        else if (dot >= len2) u <= 17'h10000;
        else u <= '0;
      end
      csns_pkg::OP_DIV: begin
        rem <= ge ? rem2 - 41'(len2) : rem2;
        u   <= {u[15:0], ge};
      end
      csns_pkg::OP_FOOT: begin
        for (int ax = 0; ax < 2; ax++) f[ax] <= 37'(v[ax]) * 37'($signed({1'b0, u}));
      end
      csns_pkg::OP_DIFF: begin
        for (int ax = 0; ax < 2; ax++) dd[ax] <= ndd[ax];
      end
      csns_pkg::OP_SQ: begin
        for (int ax = 0; ax < 2; ax++) sq[ax] <= 44'(dd[ax]) * 44'(dd[ax]);
      end
      csns_pkg::OP_CMP_OUT: begin
        if (cmd.last) begin
          // publish the result word, saturating the distance
          out_word.segment_index <= 6'(best_idx);
          out_word.nearest_dist_sq <= (best > 45'sd2147483647) ? 31'h7FFFFFFF
                                                               : best[30:0];
        end else begin
          if (cmd.seg == '0 || seg_dsq < best) begin
            best     <= seg_dsq;
            best_idx <= cmd.seg;
          end
          for (int ax = 0; ax < 2; ax++) a[ax] <= b[ax];
        end
      end
      default: begin
      end
    endcase
    if (rst) begin
      sel <= '0;
    end
  end

endmodule
`default_nettype wire
